/* rtl/septet_pack_to_hex_unit_macros.svh */
// assertion macros shared by the septet packer checker
`ifndef SEPTET_PACK_TO_HEX_UNIT_MACROS_SVH
`define SEPTET_PACK_TO_HEX_UNIT_MACROS_SVH

// checked at every edge, reset included
`define SPTH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// checked only while out of reset
`define SPTH_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

/* rtl/spth_pkg.sv */
// package with widths and the hex digit encoder for the septet packer
package spth_pkg;

    localparam int unsigned SEPT_W   = 7;
    localparam int unsigned HEX_W    = 7;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned BUF_W    = 16;
    localparam int unsigned LEFT_W   = 3;
    localparam int unsigned NIB_W    = 4;

    localparam logic [HEX_W-1:0] HEX_ZERO  = 7'd48;
    localparam logic [HEX_W-1:0] HEX_ALPHA = 7'd55;
    localparam logic [NIB_W-1:0] NIB_TEN   = 4'd10;

    localparam logic [LEFT_W-1:0] DIGITS_NONE = 3'd0;
    localparam logic [LEFT_W-1:0] DIGITS_ONE  = 3'd1;
    localparam logic [LEFT_W-1:0] DIGITS_PAIR = 3'd2;
    localparam logic [LEFT_W-1:0] DIGITS_QUAD = 3'd4;

    localparam logic [CNT_W-1:0] CNT_EMPTY = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_FULL  = 3'd7;

    // nibble to upper-case ascii hex
    function automatic logic [HEX_W-1:0] hex_digit(input logic [NIB_W-1:0] nib);
        logic [HEX_W-1:0] ext;
        ext = {3'b000, nib};
        if (nib < NIB_TEN) begin
            return HEX_ZERO + ext;
        end else begin
            return HEX_ALPHA + ext;
        end
    endfunction

endpackage

/* rtl/septet_pack_to_hex_unit.sv */
// top level of the gsm septet packer with hex digit output
//
// septet_pack_to_hex_unit packs 7-bit characters lsb first into octets, the gsm
// way (8 characters make 7 octets), and sends every finished octet as two
// upper-case ascii hex digits, high nibble first, one digit per output word.
// a word with i_is_last set flushes any leftover bits as a final octet with
// zero high bits, clears the carry, and its last digit carries o_end_mark.
// each input word gives 0, 2 or 4 digits. the packing is done in the cycle a
// word is taken, straight into a small digit buffer; the buffer feeds a
// registered output one digit per cycle while i_stall is low. a new word is
// taken as soon as the buffer will be empty after the current cycle, so the
// single output port sets the rate. the first digit of a word passes through
// the digit buffer and then the output register before it shows on the output.
module septet_pack_to_hex_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [spth_pkg::SEPT_W-1:0] i_char_in,
    input  logic                        i_is_last,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [spth_pkg::HEX_W-1:0]  o_hex_char,
    output logic                        o_end_mark
);

    // packing state
    logic [spth_pkg::SEPT_W-1:0] r_carry_bits, n_carry_bits;
    logic [spth_pkg::CNT_W-1:0]  r_carry_cnt,  n_carry_cnt;

    // digit buffer: octets left aligned, digits still to send, last flag
    logic [spth_pkg::BUF_W-1:0]  r_oct,  n_oct;
    logic [spth_pkg::LEFT_W-1:0] r_left, n_left;
    logic                        r_last, n_last;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [spth_pkg::HEX_W-1:0]  r_out_char,  n_out_char;
    logic                        r_out_end,   n_out_end;

    logic                        in_acc;
    logic                        load_out;
    logic                        has_carry;
    logic [2*spth_pkg::SEPT_W-1:0] acc;

    // output register may refill when empty or when its word leaves
    assign load_out = !r_out_valid || !i_stall;

    // take a word once the buffer drains this cycle
    assign o_stall = (r_left > spth_pkg::DIGITS_ONE) ||
                     ((r_left == spth_pkg::DIGITS_ONE) && !load_out);
    assign in_acc  = i_valid && !o_stall;

    // new septet shifted above the pending bits
    assign acc = {{spth_pkg::SEPT_W{1'b0}}, r_carry_bits} |
                 ({{spth_pkg::SEPT_W{1'b0}}, i_char_in} << r_carry_cnt);
    assign has_carry = (r_carry_cnt != spth_pkg::CNT_EMPTY);

    always_comb begin
        n_carry_bits = r_carry_bits;
        n_carry_cnt  = r_carry_cnt;
        n_oct        = r_oct;
        n_left       = r_left;
        n_last       = r_last;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_end    = r_out_end;

        // drain one digit into the output register
        if (load_out) begin
            n_out_valid = (r_left != spth_pkg::DIGITS_NONE);
            if (r_left != spth_pkg::DIGITS_NONE) begin
                n_out_char = spth_pkg::hex_digit(r_oct[spth_pkg::BUF_W-1 -: spth_pkg::NIB_W]);
                n_out_end  = r_last && (r_left == spth_pkg::DIGITS_ONE);
                n_oct      = r_oct << spth_pkg::NIB_W;
                n_left     = r_left - spth_pkg::DIGITS_ONE;
            end
        end

        // pack the new word
        if (in_acc) begin
            n_last = i_is_last;
            if (has_carry) begin
                // pending bits complete an octet
                if (i_is_last && (r_carry_cnt != spth_pkg::CNT_ONE)) begin
                    // leftover bits go out as one more octet
                    n_oct  = {acc[7:0], 2'b00, acc[13:8]};
                    n_left = spth_pkg::DIGITS_QUAD;
                end else begin
                    n_oct  = {acc[7:0], 8'h00};
                    n_left = spth_pkg::DIGITS_PAIR;
                end
            end else if (i_is_last) begin
                // lone septet sent as the final octet
                n_oct  = {acc[7:0], 8'h00};
                n_left = spth_pkg::DIGITS_PAIR;
            end else begin
                n_left = spth_pkg::DIGITS_NONE;
            end

            if (i_is_last) begin
                n_carry_bits = '0;
                n_carry_cnt  = spth_pkg::CNT_EMPTY;
            end else if (has_carry) begin
                n_carry_bits = {1'b0, acc[13:8]};
                n_carry_cnt  = r_carry_cnt - spth_pkg::CNT_ONE;
            end else begin
                n_carry_bits = acc[spth_pkg::SEPT_W-1:0];
                n_carry_cnt  = spth_pkg::CNT_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry_bits <= '0;
            r_carry_cnt  <= spth_pkg::CNT_EMPTY;
            r_left       <= spth_pkg::DIGITS_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_carry_bits <= n_carry_bits;
            r_carry_cnt  <= n_carry_cnt;
            r_left       <= n_left;
            r_out_valid  <= n_out_valid;
        end
        // payload, no reset needed
        r_oct      <= n_oct;
        r_last     <= n_last;
        r_out_char <= n_out_char;
        r_out_end  <= n_out_end;
    end

    assign o_valid    = r_out_valid;
    assign o_hex_char = r_out_char;
    assign o_end_mark = r_out_end;

endmodule

/* rtl/spth_check.sv */
// port level checker for the septet packer, bound to the top level
`include "septet_pack_to_hex_unit_macros.svh"

module spth_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [spth_pkg::SEPT_W-1:0] i_char_in,
    input logic                        i_is_last,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [spth_pkg::HEX_W-1:0]  o_hex_char,
    input logic                        o_end_mark
);

    logic hex_ok;

    // '0'..'9' or 'A'..'F'
    assign hex_ok = o_hex_char inside {[7'd48:7'd57], [7'd65:7'd70]};

    // no word right after reset
    `SPTH_ASSERT_ALWAYS(a_idle_after_reset, !i_rst_n |=> !o_valid, "output valid after reset")

    // only upper-case hex digits leave the block
    `SPTH_ASSERT_RUN(a_hex_range, o_valid |-> hex_ok, "output is not a hex digit")

    // a stalled digit holds
    `SPTH_ASSERT_RUN(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_hex_char) && $stable(o_end_mark), "stalled output changed")

    // a stalled input word holds
    `SPTH_ASSERT_RUN(a_in_hold, i_valid && o_stall |=> i_valid && $stable(i_char_in) && $stable(i_is_last), "stalled input changed")

    // a final word taken right after an end mark gives at least two digits
    `SPTH_ASSERT_RUN(a_end_pairs, o_valid && !i_stall && o_end_mark |=> !(o_valid && o_end_mark && !$past(i_stall) && $past(o_valid) && $past(o_end_mark)), "two end marks in a row")

endmodule

bind septet_pack_to_hex_unit spth_check u_spth_check (.*);

/* dv/tb_septet_pack_to_hex_unit.sv */
// self-checking testbench for the septet packer with hex digit output
module tb_septet_pack_to_hex_unit;

    // run shape
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned RANDOM_WORDS  = 95;   // plus the directed words, about 120 in all
    localparam int unsigned IDLE_PERCENT  = 15;
    localparam int unsigned QUIET_FROM    = 40;   // no idling on either side in this word span
    localparam int unsigned QUIET_TO      = 75;
    localparam int unsigned HOLD_AT_WORD  = 95;   // receiver backs off once past this word
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned DRAIN_CYCLES  = 20;   // room for stray digits to pass the digit buffer and output register
    localparam int unsigned CYCLE_LIMIT   = 50000;
    localparam int unsigned MAX_REPORTS   = 10;

    // one input word: a septet and its end-of-message flag
    typedef struct packed {
        logic [spth_pkg::SEPT_W-1:0] ch;
        logic                        last;
    } t_septet_word;

    // one output word: an ascii hex digit and its end-of-message mark
    typedef struct packed {
        logic [spth_pkg::HEX_W-1:0] hex;
        logic                       end_mark;
    } t_hex_digit;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    logic [spth_pkg::SEPT_W-1:0]  i_char_in  = '0;
    logic                         i_is_last  = 1'b0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    logic [spth_pkg::HEX_W-1:0]   o_hex_char;
    logic                         o_end_mark;

    t_septet_word       septet_q[$];      // words still to be offered
    t_hex_digit         digit_expect_q[$]; // digits the packer owes us, oldest first

    // packing state mirrored from the block
    logic [spth_pkg::SEPT_W-1:0]  carry_bits  = '0;
    logic [spth_pkg::CNT_W-1:0]   carry_count = '0;

    int unsigned        words_taken = 0;
    int unsigned        mismatches  = 0;
    int unsigned        cycle_count = 0;
    int unsigned        hold_left   = 0;
    logic               hold_done   = 1'b0;
    logic               quiet;

    septet_pack_to_hex_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_char_in  (i_char_in),
        .i_is_last  (i_is_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hex_char (o_hex_char),
        .o_end_mark (o_end_mark)
    );

    always #2 i_clk = ~i_clk;

    // both sides run flat out through the middle of the stream
    assign quiet = (words_taken >= QUIET_FROM) && (words_taken < QUIET_TO);

    // nibble to upper-case ascii
    function automatic logic [spth_pkg::HEX_W-1:0] nibble_ascii(
        input logic [spth_pkg::NIB_W-1:0] nib);
        logic [spth_pkg::HEX_W-1:0] code;
        if (nib > 4'd9) begin
            code = 7'h41 + {3'b000, nib - 4'd10};   // 'A'..'F'
        end else begin
            code = 7'h30 + {3'b000, nib};           // '0'..'9'
        end
        return code;
    endfunction

    // queue both digits of one octet, high nibble first
    task automatic push_octet(input logic [7:0] octet, input logic ends_msg);
        t_hex_digit d;
        d.hex      = nibble_ascii(octet[7:4]);
        d.end_mark = 1'b0;
        digit_expect_q.push_back(d);
        d.hex      = nibble_ascii(octet[3:0]);
        d.end_mark = ends_msg;
        digit_expect_q.push_back(d);
    endtask

    // pack one accepted septet and queue the digits it finishes
    task automatic pack_septet(input logic [spth_pkg::SEPT_W-1:0] ch, input logic last);
        logic [14:0] acc;
        logic [3:0]  bits;
        logic        full;
        acc  = {8'd0, carry_bits} | ({8'd0, ch} << carry_count);
        bits = {1'b0, carry_count} + 4'd7;
        full = (bits >= 4'd8);
        if (full) begin
            // on a last word with nothing left over this octet closes the message
            push_octet(acc[7:0], last && (bits == 4'd8));
            acc  = acc >> 8;
            bits = bits - 4'd8;
        end
        if (last) begin
            // leftover bits go out as a final octet with zero high bits
            if (bits != 4'd0) begin
                push_octet(acc[7:0], 1'b1);
            end
            carry_bits  <= '0;
            carry_count <= '0;
        end else begin
            carry_bits  <= acc[6:0];
            carry_count <= bits[2:0];
        end
    endtask

    task automatic add_word(input logic [spth_pkg::SEPT_W-1:0] ch, input logic last);
        t_septet_word w;
        w.ch   = ch;
        w.last = last;
        septet_q.push_back(w);
    endtask

    // sender: offers queued words, holds a word steady while stalled
    always @(posedge i_clk) begin : sender
        t_septet_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pack_septet(i_char_in, i_is_last);
                words_taken <= words_taken + 1;
            end
            // free to change the offer only when nothing is held or it was just taken
            if (!i_valid || !o_stall) begin
                if (septet_q.size() > 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                    w = septet_q.pop_front();
                    i_valid   <= 1'b1;
                    i_char_in <= w.ch;
                    i_is_last <= w.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && words_taken >= HOLD_AT_WORD) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // checker: every taken digit against the oldest owed digit
    always @(posedge i_clk) begin : digit_check
        t_hex_digit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digit_expect_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected digit hex=%02h end=%b at cycle %0d",
                             o_hex_char, o_end_mark, cycle_count);
                end
            end else begin
                want = digit_expect_q.pop_front();
                if (o_hex_char !== want.hex || o_end_mark !== want.end_mark) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS) begin
                        $display("digit mismatch at cycle %0d: hex exp=%02h got=%02h,",
                                 cycle_count, want.hex, o_hex_char,
                                 " end exp=%b got=%b", want.end_mark, o_end_mark);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned len;
        int unsigned k;
        logic [spth_pkg::SEPT_W-1:0] ch;

        // single last word with empty carry, both extremes
        add_word(7'h7F, 1'b1);
        add_word(7'h00, 1'b1);
        // eight words: no leftover, end mark on last digit of the last full octet
        add_word(7'h7F, 1'b0);
        add_word(7'h00, 1'b0);
        add_word(7'h55, 1'b0);
        add_word(7'h2A, 1'b0);
        add_word(7'h7F, 1'b0);
        add_word(7'h7F, 1'b0);
        add_word(7'h01, 1'b0);
        add_word(7'h40, 1'b1);
        // short message ending with leftover bits, four digits on the last word
        add_word(7'h41, 1'b0);
        add_word(7'h42, 1'b1);
        // seven all-ones words, carry walks through counts 0 and 7 down to 2
        for (k = 0; k < 7; k++) begin
            add_word(7'h7F, k == 6);
        end

        // random messages, mostly short, some long
        while (septet_q.size() < 19 + RANDOM_WORDS) begin
            if ($urandom_range(9) < 7) begin
                len = $urandom_range(9, 1);
            end else begin
                len = $urandom_range(24, 10);
            end
            for (k = 0; k < len; k++) begin
                case ($urandom_range(7))
                    0:       ch = 7'h00;
                    1:       ch = 7'h7F;
                    default: ch = 7'($urandom_range(127));
                endcase
                add_word(ch, k == len - 1);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all words taken and every owed digit seen
        @(posedge i_clk);
        while (septet_q.size() != 0 || i_valid || digit_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray digit surface
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && digit_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
